[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/iptc_pkg.sv]
// Types and constants of the IP address text classifier
package iptc_pkg;

    localparam int unsigned ChW      = 8;
    localparam int unsigned KindW    = 2;
    localparam int unsigned LenW     = 6;
    localparam int unsigned GcntW    = 4;
    localparam int unsigned GlenW    = 3;
    localparam int unsigned GvalW    = 10;
    localparam int unsigned OutDataW = 8;

    localparam logic [LenW-1:0]  LenSat   = 6'd40;
    localparam logic [LenW-1:0]  LenMin   = 6'd7;
    localparam logic [LenW-1:0]  LenMax   = 6'd39;
    localparam logic [LenW-1:0]  LenMaxV4 = 6'd19;
    localparam logic [LenW-1:0]  LenMinV6 = 6'd15;
    localparam logic [GcntW-1:0] GcntSat  = 4'd9;
    localparam logic [GcntW-1:0] GroupsV4 = 4'd4;
    localparam logic [GcntW-1:0] GroupsV6 = 4'd8;
    localparam logic [GlenW-1:0] GlenSat  = 3'd5;
    localparam logic [GlenW-1:0] GlenMaxV4 = 3'd3;
    localparam logic [GlenW-1:0] GlenMaxV6 = 3'd4;
    localparam logic [GvalW-1:0] OctetMax = 10'd255;

    localparam logic [ChW-1:0] ChDot   = 8'h2E;
    localparam logic [ChW-1:0] ChColon = 8'h3A;
    localparam logic [ChW-1:0] ChZero  = 8'h30;
    localparam logic [ChW-1:0] ChNine  = 8'h39;
    localparam logic [ChW-1:0] ChUpA   = 8'h41;
    localparam logic [ChW-1:0] ChUpF   = 8'h46;
    localparam logic [ChW-1:0] ChLoA   = 8'h61;
    localparam logic [ChW-1:0] ChLoF   = 8'h66;

    localparam logic [KindW-1:0] KindNone = 2'd0;
    localparam logic [KindW-1:0] KindV4   = 2'd1;
    localparam logic [KindW-1:0] KindV6   = 2'd2;

    typedef struct packed {
        logic       dot;
        logic       colon;
        logic       dec;
        logic       hex;
        logic       zero;
        logic [3:0] digit;
    } t_char_class;

endpackage

[hw/rtl/iptc_char_dec.sv]
// Character class decoder for one address character
module iptc_char_dec
    import iptc_pkg::*;
(
    input  logic [ChW-1:0] i_ch,
    output t_char_class    o_cls
);

    logic       dec;
    logic       letter;
    logic [ChW-1:0] diff;

    assign dec    = (i_ch >= ChZero) && (i_ch <= ChNine);
    assign letter = ((i_ch >= ChUpA) && (i_ch <= ChUpF)) ||
                    ((i_ch >= ChLoA) && (i_ch <= ChLoF));
    assign diff   = i_ch - ChZero;

    always_comb begin
        o_cls.dot   = (i_ch == ChDot);
        o_cls.colon = (i_ch == ChColon);
        o_cls.dec   = dec;
        o_cls.hex   = dec || letter;
        o_cls.zero  = (i_ch == ChZero);
        o_cls.digit = diff[3:0];
    end

endmodule

[hw/rtl/iptc_track.sv]
// Group and length tracking registers with the end-of-string classification
module iptc_track
    import iptc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_last,
    input  t_char_class      i_cls,
    output logic [KindW-1:0] o_kind
);

    logic [LenW-1:0]  r_len,   n_len;
    logic             r_dot,   n_dot;
    logic             r_col,   n_col;
    logic [GcntW-1:0] r_gcnt,  n_gcnt;
    logic [GlenW-1:0] r_glen,  n_glen;
    logic [GvalW-1:0] r_gval,  n_gval;
    logic             r_fz,    n_fz;
    logic             r_alld,  n_alld;
    logic             r_allh,  n_allh;
    logic             r_fail,  n_fail;

    logic             v4_ok_cur;
    logic             v6_ok_cur;
    logic             v4_ok_fin;
    logic             v6_ok_fin;
    logic             fin_ok;
    logic             fin_fail;
    logic [GcntW-1:0] fin_gcnt;
    logic [GcntW-1:0] gcnt_inc;

    function automatic logic v4_rule(input logic [GlenW-1:0] glen,
                                     input logic             alld,
                                     input logic [GvalW-1:0] gval,
                                     input logic             fz);
        v4_rule = (glen != '0) && (glen <= GlenMaxV4) && alld &&
                  (gval <= OctetMax) && !((glen > 3'd1) && fz);
    endfunction

    function automatic logic v6_rule(input logic [GlenW-1:0] glen,
                                     input logic             allh);
        v6_rule = (glen != '0) && (glen <= GlenMaxV6) && allh;
    endfunction

    assign v4_ok_cur = v4_rule(r_glen, r_alld, r_gval, r_fz);
    assign v6_ok_cur = v6_rule(r_glen, r_allh);
    assign gcnt_inc  = (r_gcnt < GcntSat) ? r_gcnt + 4'd1 : r_gcnt;

    // state after this character, before any end-of-string handling
    always_comb begin
        n_len  = (r_len < LenSat) ? r_len + 6'd1 : r_len;
        n_dot  = r_dot;
        n_col  = r_col;
        n_gcnt = r_gcnt;
        n_glen = r_glen;
        n_gval = r_gval;
        n_fz   = r_fz;
        n_alld = r_alld;
        n_allh = r_allh;
        n_fail = r_fail;
        if (i_cls.dot || i_cls.colon) begin
            n_dot  = r_dot | i_cls.dot;
            n_col  = r_col | i_cls.colon;
            n_fail = r_fail | (i_cls.dot ? !v4_ok_cur : !v6_ok_cur);
            n_gcnt = gcnt_inc;
            n_glen = '0;
            n_gval = '0;
            n_fz   = 1'b0;
            n_alld = 1'b1;
            n_allh = 1'b1;
        end else begin
            if (r_glen == '0) begin
                n_fz = i_cls.zero;
            end
            if (!i_cls.dec) begin
                n_alld = 1'b0;
            end else if (r_glen < GlenMaxV4) begin
                // times ten as two shifts
                n_gval = (r_gval << 3) + (r_gval << 1) + {6'd0, i_cls.digit};
            end
            if (!i_cls.hex) begin
                n_allh = 1'b0;
            end
            if (r_glen < GlenSat) begin
                n_glen = r_glen + 3'd1;
            end
        end
    end

    // final group is closed under the rules of the separator seen
    assign v4_ok_fin = v4_rule(n_glen, n_alld, n_gval, n_fz);
    assign v6_ok_fin = v6_rule(n_glen, n_allh);
    assign fin_ok    = n_dot ? v4_ok_fin : v6_ok_fin;
    assign fin_fail  = n_fail | !fin_ok;
    assign fin_gcnt  = (n_gcnt < GcntSat) ? n_gcnt + 4'd1 : n_gcnt;

    always_comb begin
        o_kind = KindNone;
        if ((n_dot != n_col) && !fin_fail && (n_len >= LenMin) && (n_len <= LenMax)) begin
            priority if (n_dot && (n_len <= LenMaxV4) && (fin_gcnt == GroupsV4)) begin
                o_kind = KindV4;
            end else if (n_col && (n_len >= LenMinV6) && (fin_gcnt == GroupsV6)) begin
                o_kind = KindV6;
            end else begin
                o_kind = KindNone;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_len  <= '0;
            r_dot  <= 1'b0;
            r_col  <= 1'b0;
            r_gcnt <= '0;
            r_glen <= '0;
            r_gval <= '0;
            r_fz   <= 1'b0;
            r_alld <= 1'b1;
            r_allh <= 1'b1;
            r_fail <= 1'b0;
        end else if (i_step) begin
            r_len  <= n_len;
            r_dot  <= n_dot;
            r_col  <= n_col;
            r_gcnt <= n_gcnt;
            r_glen <= n_glen;
            r_gval <= n_gval;
            r_fz   <= n_fz;
            r_alld <= n_alld;
            r_allh <= n_allh;
            r_fail <= n_fail;
        end
    end

endmodule

[hw/rtl/ip_address_text_classifier_unit.sv]
// IP address text classifier: one character per word in, one kind per string out
//
// Slave channel: one character per word in i_s_tdata, i_s_tlast on the final
// character of each address string. Master channel: one word per string, sent
// after its final character, o_m_tdata[1:0] = 0 neither, 1 IPv4, 2 IPv6.
// An accepted word sits in the input register until consumed; consuming it
// updates the group trackers, and a final character's result then enters the
// queue and shows on o_m_tvalid. Throughput is one character per cycle unless
// a final character waits on a full queue; the tracker is a single short step
// of compare and small add logic between the input register and the state.
// Results go into a two-entry output queue, so o_s_tready does not depend on
// i_m_tready. While the receiver stalls, characters keep flowing until a final
// character finds the queue full; it then waits in the input register and
// o_s_tready falls once that register is taken.
// Reset (i_rst_n low, synchronous) empties the input register and the queue and
// clears the trackers to the start of a string. All tracking state also
// clears after each final character.
module ip_address_text_classifier_unit
    import iptc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [ChW-1:0]      i_s_tdata,   // [7:0] ch
    input  logic                i_s_tlast,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [OutDataW-1:0] o_m_tdata    // [1:0] kind, [7:2] zero
);

`include "assert_macros.svh"

    logic             r_in_valid;
    logic [ChW-1:0]   r_in_ch;
    logic             r_in_last;
    logic             in_acc;
    logic             consume;
    logic             push;
    logic             pop;
    logic [1:0]       r_q_cnt;
    logic [KindW-1:0] r_q [2];
    logic             wr_idx;
    logic [KindW-1:0] kind;
    t_char_class      cls;

    assign consume    = r_in_valid && (!r_in_last || (r_q_cnt != 2'd2));
    assign o_s_tready = !r_in_valid || consume;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign push       = consume && r_in_last;
    assign pop        = (r_q_cnt != 2'd0) && i_m_tready;
    assign wr_idx     = pop ? 1'b0 : r_q_cnt[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc || (r_in_valid && !consume);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_ch   <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    iptc_char_dec u_dec (
        .i_ch  (r_in_ch),
        .o_cls (cls)
    );

    iptc_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (consume),
        .i_last  (r_in_last),
        .i_cls   (cls),
        .o_kind  (kind)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= '0;
        end else begin
            r_q_cnt <= r_q_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // a push into the head slot takes precedence over the shift on pop
    always_ff @(posedge i_clk) begin
        if (push && !wr_idx) begin
            r_q[0] <= kind;
        end else if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (push && wr_idx) begin
            r_q[1] <= kind;
        end
    end

    assign o_m_tvalid = (r_q_cnt != 2'd0);
    assign o_m_tdata  = {{(OutDataW-KindW){1'b0}}, r_q[0]};

    `ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, push, r_q_cnt != 2'd2,
        "result pushed into a full queue")
    `ASSERT_IMPLIES(a_kind_legal, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[1:0] != 2'd3,
        "illegal kind code on output")
    `ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, push, o_m_tvalid,
        "final character produced no result")
    `ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, in_acc, r_in_valid,
        "accepted word not held in input register")

endmodule
